@@ hw/rtl/tpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone pattern generator package
// Shared types, fixed constants and divider interface structs.
// ----------------------------------------------------------------------------
package tpg_pkg;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 17;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam logic [3:0]  VOLUME_MAX       = 4'd10;
   localparam logic [3:0]  VOLUME_MIN       = 4'd1;
   localparam logic [15:0] DEFAULT_PITCH_HZ = 16'd2000;
   localparam int          ALARM_BEEP_MS    = 2000;
   localparam int          ALARM_NOISE_MS   = 1000;
   localparam int          ALARM_PULSE_MS   = 100;

   localparam logic [16:0] ALARM_BEEP_LIM   = 17'(ALARM_BEEP_MS);
   localparam logic [16:0] ALARM_CYCLE_MS   = 17'(ALARM_BEEP_MS + ALARM_NOISE_MS);
   localparam logic [16:0] ALARM_PULSE_LIM  = 17'(ALARM_PULSE_MS);
   localparam logic [16:0] ALARM_PULSE2_MS  = 17'(2 * ALARM_PULSE_MS);

   localparam logic [15:0] BEEP_MS          = 16'd200;
   localparam logic [15:0] NOISE_LOW_HZ     = 16'd100;
   localparam logic [16:0] NOISE_SPAN_HZ    = 17'(10000 - 100);
   localparam logic [9:0]  INTENSITY_FULL   = 10'd1000;
   localparam logic [4:0]  LEVEL_CAP        = 5'd10;

   typedef enum logic [2:0] {
      OP_HIGHER  = 3'd0,
      OP_LOWER   = 3'd1,
      OP_LOUDER  = 3'd2,
      OP_QUIETER = 3'd3,
      OP_BEEP    = 3'd4,
      OP_ALERT   = 3'd5,
      OP_ALARM   = 3'd6,
      OP_OFF     = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_PITCH_MIN    = 3'd0,
      CSR_PITCH_MAX    = 3'd1,
      CSR_PITCH_STEP   = 3'd2,
      CSR_PERIOD_START = 3'd3,
      CSR_PERIOD_END   = 3'd4,
      CSR_ON_START     = 3'd5,
      CSR_ON_END       = 3'd6,
      CSR_ALARM_TONE   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_LEVEL,
      ST_DIV_PERIOD,
      ST_DIV_ON,
      ST_MOD_PHASE,
      ST_MOD_CYCLE,
      ST_MOD_PULSE,
      ST_MOD_NOISE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

endpackage

@@ hw/rtl/tone_pattern_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone pattern generator
// Speaker drive word generator with pitch and volume state.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_tvalid/tready   | tuser opcode, tdata operands
//  rsp     | out       | rsp_tvalid/tready   | tuser drive flag, tdata tone
//  csr     | in        | csr_wen             | csr_index, csr_wdata
//
//  Adjust, beep and off requests go straight to the emit state; alarm runs
//  the shared 32-step divider twice and alert four times (three with a zero
//  period).
//  req_tready is high only when the sequencer is idle; a finished result
//  waits in the output register while the next request is taken.
//  Reset is synchronous and restores pitch, volume, the CSRs, the state and rsp_tvalid.
// ----------------------------------------------------------------------------
module tone_pattern_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] opcode
   input  logic [2:0]                        req_tuser,
   // [9:0] intensity, [41:10] time_ms, [57:42] random_word, [63:58] zero
   input  logic [tpg_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] drive_change
   output logic                              rsp_tuser,
   // [0] tone_on, [16:1] tone_hz, [20:17] tone_level, [36:21] duration_ms,
   // [39:37] zero
   output logic [tpg_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wen,
   input  logic [tpg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tpg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   tpg_pkg::state_type state_ff, state_in;

   logic [15:0] pitch_ff, pitch_in;
   logic [3:0]  volume_ff, volume_in;

   logic [15:0] pitch_min_ff, pitch_max_ff, period_start_ff, period_end_ff;
   logic [15:0] on_start_ff, on_end_ff, alarm_tone_ff;
   logic [11:0] pitch_step_ff;

   logic [9:0]  xi_ff, xi_in;
   logic [31:0] time_ff, time_in;
   logic [15:0] rand_ff, rand_in;
   logic [3:0]  level_ff, level_in;
   logic [16:0] per_ff, per_in;
   logic [16:0] len_ff, len_in;
   logic [16:0] cyc_ff, cyc_in;

   logic        w_drive_ff, w_drive_in;
   logic        w_tone_ff, w_tone_in;
   logic [15:0] w_hz_ff, w_hz_in;
   logic [3:0]  w_level_ff, w_level_in;
   logic [15:0] w_dur_ff, w_dur_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_user_ff, rsp_user_in;
   logic [tpg_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   tpg_pkg::div_req_type div_req;
   tpg_pkg::div_rsp_type div_rsp;

   logic               accept;
   tpg_pkg::opcode_type op;
   logic [9:0]         req_intensity;
   logic [16:0]        pitch_sum;
   logic [16:0]        pitch_floor;
   logic [4:0]         vol_up;
   logic [15:0]        map_from, map_to;
   logic signed [17:0] map_diff;
   logic signed [28:0] map_prod;
   logic [28:0]        map_mag;
   logic [16:0]        map_q;
   logic [17:0]        map_val;
   logic [13:0]        lvl_prod;
   logic [4:0]         lvl_sum;
   logic               div_idle;
   logic               emit_load;

   tpg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready    = state_ff == tpg_pkg::ST_IDLE;
   assign accept        = req_tvalid && req_tready;
   assign op            = tpg_pkg::opcode_type'(req_tuser);
   assign req_intensity = req_tdata[9:0];

   always_comb begin
      pitch_sum   = {1'b0, pitch_ff} + {5'b0, pitch_step_ff};
      pitch_floor = {5'b0, pitch_step_ff} + {1'b0, pitch_min_ff};
      vol_up      = {1'b0, volume_ff} + 5'd1;

      map_from = (state_ff == tpg_pkg::ST_DIV_ON) ? on_start_ff : period_start_ff;
      map_to   = (state_ff == tpg_pkg::ST_DIV_ON) ? on_end_ff : period_end_ff;
      map_diff = $signed({2'b0, map_to}) + 18'sd1 - $signed({2'b0, map_from});
      map_prod = $signed({1'b0, xi_ff}) * map_diff;
      map_mag  = map_prod[28] ? 29'(-map_prod) : 29'(map_prod);
      map_q    = div_rsp.quotient[16:0];
      map_val  = map_diff[17] ? ({2'b0, map_from} - {1'b0, map_q})
                              : ({2'b0, map_from} + {1'b0, map_q});

      lvl_prod = xi_ff * volume_ff;
      lvl_sum  = {1'b0, div_rsp.quotient[3:0]} + 5'd1;
      div_idle = !div_rsp.busy && !div_rsp.done;
      emit_load = (state_ff == tpg_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in   = state_ff;
      pitch_in   = pitch_ff;
      volume_in  = volume_ff;
      xi_in      = xi_ff;
      time_in    = time_ff;
      rand_in    = rand_ff;
      level_in   = level_ff;
      per_in     = per_ff;
      len_in     = len_ff;
      cyc_in     = cyc_ff;
      w_drive_in = w_drive_ff;
      w_tone_in  = w_tone_ff;
      w_hz_in    = w_hz_ff;
      w_level_in = w_level_ff;
      w_dur_in   = w_dur_ff;

      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = 17'(tpg_pkg::INTENSITY_FULL);

      case (state_ff)
         tpg_pkg::ST_IDLE: begin
            if (accept) begin
               xi_in      = (req_intensity > tpg_pkg::INTENSITY_FULL) ?
                            tpg_pkg::INTENSITY_FULL : req_intensity;
               time_in    = req_tdata[41:10];
               rand_in    = req_tdata[57:42];
               w_drive_in = 1'b1;
               w_tone_in  = 1'b0;
               w_hz_in    = '0;
               w_level_in = '0;
               w_dur_in   = '0;
               state_in   = tpg_pkg::ST_EMIT;
               case (op)
                  tpg_pkg::OP_HIGHER: begin
                     w_drive_in = 1'b0;
                     pitch_in   = (pitch_sum < {1'b0, pitch_max_ff}) ?
                                  pitch_sum[15:0] : pitch_max_ff;
                  end
                  tpg_pkg::OP_LOWER: begin
                     w_drive_in = 1'b0;
                     pitch_in   = ({1'b0, pitch_ff} > pitch_floor) ?
                                  16'(pitch_ff - {4'b0, pitch_step_ff}) : pitch_min_ff;
                  end
                  tpg_pkg::OP_LOUDER: begin
                     w_drive_in = 1'b0;
                     volume_in  = (vol_up < {1'b0, tpg_pkg::VOLUME_MAX}) ?
                                  vol_up[3:0] : tpg_pkg::VOLUME_MAX;
                  end
                  tpg_pkg::OP_QUIETER: begin
                     w_drive_in = 1'b0;
                     volume_in  = ({1'b0, volume_ff} > ({1'b0, tpg_pkg::VOLUME_MIN} + 5'd1)) ?
                                  4'(volume_ff - 4'd1) : tpg_pkg::VOLUME_MIN;
                  end
                  tpg_pkg::OP_BEEP: begin
                     w_tone_in  = 1'b1;
                     w_hz_in    = pitch_ff;
                     w_level_in = volume_ff;
                     w_dur_in   = tpg_pkg::BEEP_MS;
                  end
                  tpg_pkg::OP_ALERT: state_in = tpg_pkg::ST_DIV_LEVEL;
                  tpg_pkg::OP_ALARM: state_in = tpg_pkg::ST_MOD_CYCLE;
                  tpg_pkg::OP_OFF: ;
                  default: ;
               endcase
            end
         end
         tpg_pkg::ST_DIV_LEVEL: begin
            div_req.start    = div_idle;
            div_req.dividend = {18'b0, lvl_prod};
            if (div_rsp.done) begin
               level_in = (lvl_sum > tpg_pkg::LEVEL_CAP) ? tpg_pkg::LEVEL_CAP[3:0] : lvl_sum[3:0];
               state_in = tpg_pkg::ST_DIV_PERIOD;
            end
         end
         tpg_pkg::ST_DIV_PERIOD: begin
            div_req.start    = div_idle;
            div_req.dividend = {3'b0, map_mag};
            if (div_rsp.done) begin
               per_in   = map_val[16:0];
               state_in = tpg_pkg::ST_DIV_ON;
            end
         end
         tpg_pkg::ST_DIV_ON: begin
            div_req.start    = div_idle;
            div_req.dividend = {3'b0, map_mag};
            if (div_rsp.done) begin
               len_in   = map_val[16:0];
               state_in = tpg_pkg::ST_MOD_PHASE;
            end
         end
         tpg_pkg::ST_MOD_PHASE: begin
            div_req.dividend = time_ff;
            div_req.divisor  = per_ff;
            if (per_ff == '0) begin
               w_tone_in = len_ff != '0;
               state_in  = tpg_pkg::ST_EMIT;
            end else begin
               div_req.start = div_idle;
               if (div_rsp.done) begin
                  w_tone_in = div_rsp.remainder < len_ff;
                  state_in  = tpg_pkg::ST_EMIT;
               end
            end
            w_hz_in    = w_tone_in ? pitch_ff : '0;
            w_level_in = w_tone_in ? level_ff : '0;
         end
         tpg_pkg::ST_MOD_CYCLE: begin
            div_req.start    = div_idle;
            div_req.dividend = time_ff;
            div_req.divisor  = tpg_pkg::ALARM_CYCLE_MS;
            if (div_rsp.done) begin
               cyc_in   = div_rsp.remainder;
               state_in = (div_rsp.remainder <= tpg_pkg::ALARM_BEEP_LIM) ?
                          tpg_pkg::ST_MOD_PULSE : tpg_pkg::ST_MOD_NOISE;
            end
         end
         tpg_pkg::ST_MOD_PULSE: begin
            div_req.start    = div_idle;
            div_req.dividend = {15'b0, cyc_ff};
            div_req.divisor  = tpg_pkg::ALARM_PULSE2_MS;
            if (div_rsp.done) begin
               w_tone_in  = div_rsp.remainder > tpg_pkg::ALARM_PULSE_LIM;
               w_hz_in    = w_tone_in ? alarm_tone_ff : '0;
               w_level_in = w_tone_in ? tpg_pkg::VOLUME_MAX : '0;
               state_in   = tpg_pkg::ST_EMIT;
            end
         end
         tpg_pkg::ST_MOD_NOISE: begin
            div_req.start    = div_idle;
            div_req.dividend = {16'b0, rand_ff};
            div_req.divisor  = tpg_pkg::NOISE_SPAN_HZ;
            if (div_rsp.done) begin
               w_tone_in  = 1'b1;
               w_hz_in    = tpg_pkg::NOISE_LOW_HZ + div_rsp.remainder[15:0];
               w_level_in = tpg_pkg::VOLUME_MAX;
               state_in   = tpg_pkg::ST_EMIT;
            end
         end
         tpg_pkg::ST_EMIT: begin
            if (emit_load) begin
               state_in = tpg_pkg::ST_IDLE;
            end
         end
         default: state_in = tpg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = w_drive_ff;
         rsp_data_in  = {3'b0, w_dur_ff, w_level_ff, w_hz_ff, w_tone_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tpg_pkg::ST_IDLE;
         pitch_ff        <= tpg_pkg::DEFAULT_PITCH_HZ;
         volume_ff       <= tpg_pkg::VOLUME_MAX;
         rsp_valid_ff    <= 1'b0;
         pitch_min_ff    <= 16'd200;
         pitch_max_ff    <= 16'd8000;
         pitch_step_ff   <= 12'd100;
         period_start_ff <= 16'd1000;
         period_end_ff   <= 16'd200;
         on_start_ff     <= 16'd50;
         on_end_ff       <= 16'd150;
         alarm_tone_ff   <= 16'd3000;
      end else begin
         state_ff     <= state_in;
         pitch_ff     <= pitch_in;
         volume_ff    <= volume_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (tpg_pkg::csr_index_type'(csr_index))
               tpg_pkg::CSR_PITCH_MIN:    pitch_min_ff    <= csr_wdata;
               tpg_pkg::CSR_PITCH_MAX:    pitch_max_ff    <= csr_wdata;
               tpg_pkg::CSR_PITCH_STEP:   pitch_step_ff   <= csr_wdata[11:0];
               tpg_pkg::CSR_PERIOD_START: period_start_ff <= csr_wdata;
               tpg_pkg::CSR_PERIOD_END:   period_end_ff   <= csr_wdata;
               tpg_pkg::CSR_ON_START:     on_start_ff     <= csr_wdata;
               tpg_pkg::CSR_ON_END:       on_end_ff       <= csr_wdata;
               tpg_pkg::CSR_ALARM_TONE:   alarm_tone_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      xi_ff       <= xi_in;
      time_ff     <= time_in;
      rand_ff     <= rand_in;
      level_ff    <= level_in;
      per_ff      <= per_in;
      len_ff      <= len_in;
      cyc_ff      <= cyc_in;
      w_drive_ff  <= w_drive_in;
      w_tone_ff   <= w_tone_in;
      w_hz_ff     <= w_hz_in;
      w_level_ff  <= w_level_in;
      w_dur_ff    <= w_dur_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/tpg_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone pattern generator divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by all jobs.
// ----------------------------------------------------------------------------
module tpg_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tpg_pkg::div_req_type div_req,
   output tpg_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tpg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [tpg_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [tpg_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [tpg_pkg::DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [tpg_pkg::DIVISOR_W:0] trial;
   logic [tpg_pkg::DIVISOR_W:0] trial_sub;
   logic                        fits;
   logic                        last_step;

   always_comb begin
      trial     = {rem_ff, quo_ff[tpg_pkg::DIVIDEND_W-1]};
      fits      = trial >= {1'b0, dvs_ff};
      trial_sub = trial - {1'b0, dvs_ff};
      last_step = cnt_ff == tpg_pkg::DIV_CNT_W'(tpg_pkg::DIVIDEND_W - 1);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[tpg_pkg::DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial_sub[tpg_pkg::DIVISOR_W-1:0] : trial[tpg_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

@@ hw/rtl/tpg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone pattern generator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tpg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic                            rsp_tuser,
   input logic [tpg_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_silence_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata == '0)
      else $error("silent result carries tone fields");

   a_adjust_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("adjust result is not all zero");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready again right after a request");

endmodule

bind tone_pattern_generator tpg_checker u_tpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
